@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sfla_pkg.sv @@
package sfla_pkg;

  localparam int SIZE_W = 16;
  localparam int ADDR_W = 16;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PASS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OOM  = 2'd2;

  // Link memory: one 16-bit word per 8-byte granule.
  localparam int LINK_DEPTH = 8192;
  localparam int LINK_AW    = 13;

  // Controller states, also the operation the datapath carries out.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_DEC   = 3'd1;
  localparam logic [ST_W-1:0] ST_HITRD = 3'd2;
  localparam logic [ST_W-1:0] ST_CARVE = 3'd3;
  localparam logic [ST_W-1:0] ST_HEAP  = 3'd4;
  localparam logic [ST_W-1:0] ST_THR1  = 3'd5;
  localparam logic [ST_W-1:0] ST_THR   = 3'd6;
  localparam logic [ST_W-1:0] ST_OUT   = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            accept;
  } sfla_cmd_t;

  typedef struct packed {
    logic oversize;
    logic is_free;
    logic head_zero;
    logic fit_one;
    logic heap_ok;
    logic more;
    logic out_free;
  } sfla_stat_t;

endpackage

@@ rtl/segregated_free_list_allocator.sv @@
// Segregated free-list allocator for small blocks, 8-byte size classes.
// Input channel s_*: one item per allocate or free request. s_tuser is the
// command (0 allocate, 1 free); s_tdata carries size and block address.
// Output channel m_*: exactly one item per request, in request order,
// with the granted address in m_tdata and the status in m_tuser
// (0 done, 1 size too large and passed to the system, 2 out of memory).
// One request is worked on at a time. A free or oversized request goes
// from decode straight to output, an allocate that hits its free list
// first reads the next link, and a miss carves blocks from the pool, or
// from the bump heap when the pool must be refilled, and threads them
// into its list. The result becomes valid as the controller returns to
// idle. The miss cost is set by threading one link word per cycle
// through the single write port of the link memory.
// The finished item sits in an output register; a new request is taken
// while it waits, but the next result is held until the receiver takes
// the previous one, so a stalled receiver stalls the block after one
// further item.
// Reset empties every list and the pool and restarts the heap at address
// 8; the link memory is not cleared and is written before it is read.
module segregated_free_list_allocator #(
  parameter int HEAP_BYTES      = 65536,
  parameter int NUM_CLASSES     = 16,
  parameter int MAX_SMALL_BYTES = 128,
  parameter int BATCH_BLOCKS    = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [15:0] size_bytes, [31:16] block_address
  input  logic        s_tuser,  // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [15:0] result_address
  output logic [1:0]  m_tuser   // [1:0] status
);

  // The controller sequences each request; the datapath holds the lists.
  sfla_pkg::sfla_cmd_t  cmd;
  sfla_pkg::sfla_stat_t st;

  sfla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  sfla_dp #(
    .HEAP_BYTES     (HEAP_BYTES),
    .NUM_CLASSES    (NUM_CLASSES),
    .MAX_SMALL_BYTES(MAX_SMALL_BYTES),
    .BATCH_BLOCKS   (BATCH_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_free  (s_tuser),
    .in_size  (s_tdata[15:0]),
    .in_addr  (s_tdata[31:16]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_addr (m_tdata),
    .out_stat (m_tuser)
  );

`include "assert_macros.svh"

  // One request at a time: taking an item closes the input.
  `SFLA_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken")

  // A result appears only when the controller hands it over.
  `SFLA_ASSERT_NEXT(a_out_from_ctrl, !m_tvalid && cmd.op != sfla_pkg::ST_OUT, !m_tvalid, "stray")

  // Every status other than done comes with a null address.
  `SFLA_ASSERT_NOW(a_null_on_fail, m_tvalid && m_tuser != sfla_pkg::STAT_DONE, m_tdata == '0, "addr")

endmodule

@@ rtl/sfla_ram.sv @@
module sfla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sfla_ctrl.sv @@
module sfla_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfla_pkg::sfla_stat_t st,
  output sfla_pkg::sfla_cmd_t  cmd
);

  logic [sfla_pkg::ST_W-1:0] state;
  logic [sfla_pkg::ST_W-1:0] state_next;

  assign in_ready   = (state == sfla_pkg::ST_IDLE);
  assign cmd.op     = state;
  assign cmd.accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      sfla_pkg::ST_IDLE: begin
        if (cmd.accept) state_next = sfla_pkg::ST_DEC;
      end
      sfla_pkg::ST_DEC: begin
        if (st.oversize || st.is_free) state_next = sfla_pkg::ST_OUT;
        else if (!st.head_zero)        state_next = sfla_pkg::ST_HITRD;
        else                           state_next = sfla_pkg::ST_CARVE;
      end
      sfla_pkg::ST_HITRD: state_next = sfla_pkg::ST_OUT;
      sfla_pkg::ST_CARVE: begin
        state_next = st.fit_one ? sfla_pkg::ST_THR1 : sfla_pkg::ST_HEAP;
      end
      sfla_pkg::ST_HEAP: begin
        state_next = st.heap_ok ? sfla_pkg::ST_THR1 : sfla_pkg::ST_OUT;
      end
      sfla_pkg::ST_THR1, sfla_pkg::ST_THR: begin
        state_next = st.more ? sfla_pkg::ST_THR : sfla_pkg::ST_OUT;
      end
      sfla_pkg::ST_OUT: begin
        if (st.out_free) state_next = sfla_pkg::ST_IDLE;
      end
      default: state_next = sfla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/sfla_dp.sv @@
module sfla_dp #(
  parameter int HEAP_BYTES      = 65536,
  parameter int NUM_CLASSES     = 16,
  parameter int MAX_SMALL_BYTES = 128,
  parameter int BATCH_BLOCKS    = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfla_pkg::sfla_cmd_t           cmd,
  output sfla_pkg::sfla_stat_t          st,
  input  logic                          in_free,
  input  logic [sfla_pkg::SIZE_W-1:0]   in_size,
  input  logic [sfla_pkg::ADDR_W-1:0]   in_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfla_pkg::ADDR_W-1:0]   out_addr,
  output logic [sfla_pkg::STAT_W-1:0]   out_stat
);

  localparam int CW = $clog2(NUM_CLASSES);
  localparam int HW = $clog2(HEAP_BYTES + 1);
  localparam int AW = (HW > sfla_pkg::ADDR_W) ? HW : sfla_pkg::ADDR_W;
  localparam int EW = AW + 2;
  localparam int BW = $clog2(NUM_CLASSES * 8 + 1);
  localparam int TW = $clog2(NUM_CLASSES * 8 * BATCH_BLOCKS + 1);

  // Decode of the incoming size.
  logic [sfla_pkg::SIZE_W-1:0] size_eff;
  logic [sfla_pkg::SIZE_W:0]   size_rnd;
  logic [sfla_pkg::SIZE_W-3:0] cls_full;
  assign size_eff = (in_size == '0) ? sfla_pkg::SIZE_W'(8) : in_size;
  assign size_rnd = {1'b0, size_eff} + (sfla_pkg::SIZE_W + 1)'(7);
  assign cls_full = size_rnd[sfla_pkg::SIZE_W:3] - (sfla_pkg::SIZE_W - 2)'(1);

  // Item registers.
  logic                        is_free;
  logic                        oversize;
  logic [CW-1:0]               cls;
  logic [BW-1:0]               blk;
  logic [sfla_pkg::ADDR_W-1:0] addr;
  logic [sfla_pkg::ADDR_W-1:0] res;
  logic [sfla_pkg::STAT_W-1:0] stat;
  logic [AW-1:0]               here;
  logic [AW-1:0]               lim;

  // Allocator state.
  logic [AW-1:0] heads [NUM_CLASSES];
  logic [AW-1:0] pool_start;
  logic [AW-1:0] pool_end;
  logic [HW-1:0] heap_total;
  logic [HW-1:0] heap_top;

  logic [TW-1:0] total;
  logic [AW-1:0] left;
  logic [AW-1:0] left_w;
  logic          donate;
  logic [CW-1:0] cls2;
  logic [CW-1:0] head_idx;
  logic [AW-1:0] head_rd;
  logic [EW-1:0] rnd;
  logic [EW-1:0] get;
  logic [AW-1:0] next_blk;
  logic          fit_full;

  assign total    = TW'(blk) * TW'(BATCH_BLOCKS);
  assign left     = pool_end - pool_start;
  assign left_w   = left >> 3;
  assign donate   = (left >= AW'(8)) && (left_w <= AW'(NUM_CLASSES));
  assign cls2     = CW'(left_w - AW'(1));
  assign head_idx = (cmd.op == sfla_pkg::ST_CARVE) ? cls2 : cls;
  assign head_rd  = heads[head_idx];
  assign rnd      = (EW'(heap_total >> 4) + EW'(7)) & ~EW'(7);
  assign get      = (EW'(total) << 1) + rnd;
  assign next_blk = here + AW'(blk);
  assign fit_full = left >= AW'(total);

  assign st.oversize  = oversize;
  assign st.is_free   = is_free;
  assign st.head_zero = (head_rd == '0);
  assign st.fit_one   = left >= AW'(blk);
  assign st.heap_ok   = (EW'(heap_top) + get) <= EW'(HEAP_BYTES);
  assign st.more      = (EW'(here) + (EW'(blk) << 1)) <= EW'(lim);
  assign st.out_free  = !out_valid || out_ready;

  // Link memory ports.
  logic                         link_we;
  logic [sfla_pkg::LINK_AW-1:0] link_waddr;
  logic [sfla_pkg::ADDR_W-1:0]  link_wdata;
  logic [sfla_pkg::LINK_AW-1:0] link_raddr;
  logic [sfla_pkg::ADDR_W-1:0]  link_rdata;

  assign link_raddr = head_rd[sfla_pkg::LINK_AW+2:3];

  // Head table write port.
  logic          head_we;
  logic [CW-1:0] head_widx;
  logic [AW-1:0] head_wdata;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = here[sfla_pkg::LINK_AW+2:3];
    link_wdata = next_blk[sfla_pkg::ADDR_W-1:0];
    head_we    = 1'b0;
    head_widx  = cls;
    head_wdata = next_blk;
    unique case (cmd.op)
      sfla_pkg::ST_DEC: begin
        if (!oversize && is_free && addr != '0) begin
          link_we    = 1'b1;
          link_waddr = addr[sfla_pkg::LINK_AW+2:3];
          link_wdata = head_rd[sfla_pkg::ADDR_W-1:0];
          head_we    = 1'b1;
          head_wdata = AW'(addr);
        end
      end
      sfla_pkg::ST_HITRD: begin
        head_we    = 1'b1;
        head_wdata = AW'(link_rdata);
      end
      sfla_pkg::ST_CARVE: begin
        if (!st.fit_one && donate) begin
          link_we    = 1'b1;
          link_waddr = pool_start[sfla_pkg::LINK_AW+2:3];
          link_wdata = head_rd[sfla_pkg::ADDR_W-1:0];
          head_we    = 1'b1;
          head_widx  = cls2;
          head_wdata = pool_start;
        end
      end
      sfla_pkg::ST_THR1: begin
        head_we = st.more;
      end
      sfla_pkg::ST_THR: begin
        link_we = 1'b1;
        if (!st.more) link_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  sfla_ram #(
    .WIDTH(sfla_pkg::ADDR_W),
    .DEPTH(sfla_pkg::LINK_DEPTH)
  ) u_links (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  // Allocator state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) heads[i] <= '0;
      pool_start <= '0;
      pool_end   <= '0;
      heap_total <= '0;
      heap_top   <= HW'(8);
      out_valid  <= 1'b0;
    end else begin
      if (head_we) heads[head_widx] <= head_wdata;
      if (cmd.op == sfla_pkg::ST_OUT && st.out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready)               out_valid <= 1'b0;
      unique case (cmd.op)
        sfla_pkg::ST_CARVE: begin
          if (!st.fit_one) pool_start <= pool_end;
        end
        sfla_pkg::ST_HEAP: begin
          if (st.heap_ok) begin
            pool_end   <= AW'(EW'(heap_top) + get);
            heap_top   <= HW'(EW'(heap_top) + get);
            heap_total <= HW'(EW'(heap_total) + get);
          end
        end
        sfla_pkg::ST_THR1, sfla_pkg::ST_THR: begin
          if (!st.more) pool_start <= next_blk;
        end
        default: begin
        end
      endcase
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_free  <= in_free;
      oversize <= (size_eff > sfla_pkg::SIZE_W'(MAX_SMALL_BYTES)) ||
                  (cls_full >= (sfla_pkg::SIZE_W - 2)'(NUM_CLASSES));
      cls      <= cls_full[CW-1:0];
      blk      <= (BW'(cls_full[CW-1:0]) + BW'(1)) << 3;
      addr     <= in_addr;
      res      <= '0;
      stat     <= sfla_pkg::STAT_DONE;
    end
    unique case (cmd.op)
      sfla_pkg::ST_DEC: begin
        if (oversize) stat <= sfla_pkg::STAT_PASS;
        else if (!is_free) res <= head_rd[sfla_pkg::ADDR_W-1:0];
      end
      sfla_pkg::ST_CARVE: begin
        here <= pool_start;
        lim  <= fit_full ? pool_start + AW'(total) : pool_end;
      end
      sfla_pkg::ST_HEAP: begin
        here <= AW'(heap_top);
        lim  <= AW'(heap_top) + AW'(total);
        if (!st.heap_ok) stat <= sfla_pkg::STAT_OOM;
      end
      sfla_pkg::ST_THR1: begin
        res <= here[sfla_pkg::ADDR_W-1:0];
        if (st.more) here <= next_blk;
      end
      sfla_pkg::ST_THR: begin
        if (st.more) here <= next_blk;
      end
      sfla_pkg::ST_OUT: begin
        if (st.out_free) begin
          out_addr <= res;
          out_stat <= stat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
